/* rtl/linear_scan_code_block_fetch_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the code-block fetch block
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LINEAR_SCAN_CODE_BLOCK_FETCH_TOP_MACROS_SVH
`define LINEAR_SCAN_CODE_BLOCK_FETCH_TOP_MACROS_SVH

`ifndef SYNTH
// Check a property on every clock edge out of reset
`define LSCBF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check that a condition is followed in the next cycle by another
`define LSCBF_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error(msg);
`else
`define LSCBF_ASSERT(lbl, prop, msg)
`define LSCBF_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

/* rtl/lscbf_pkg.sv */
// ----------------------------------------------------------------------------
// lscbf_pkg
// Shared types and constants for the linear-scan code-block fetch block.
// ----------------------------------------------------------------------------
package lscbf_pkg;

	localparam int ADDR_W     = 64;
	localparam int DATA_W     = 64;
	localparam int ENTRY_W    = 10;
	localparam int WIDX_W     = 4;
	localparam int BCOUNT_W   = 11;
	localparam int RCOUNT_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// Request type codes
	typedef enum logic [1:0] {
		REQ_REMAP = 2'd0,
		REQ_BLOCK = 2'd1,
		REQ_QUERY = 2'd2
	} lscbf_req_e;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REMAP_COUNT = 2'd1;

	// Table fill counts handed to the engine
	typedef struct packed {
		logic [BCOUNT_W-1:0] block_count;
		logic [RCOUNT_W-1:0] remap_count;
	} lscbf_counts_t;

endpackage

/* rtl/lscbf_if.sv */
// ----------------------------------------------------------------------------
// lscbf_req_if / lscbf_rsp_if
// Valid/ready channels for request items and fetched words.
// ----------------------------------------------------------------------------
interface lscbf_req_if import lscbf_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         req_type;
	logic [ENTRY_W-1:0] entry_index;
	logic [WIDX_W-1:0]  word_index;
	logic [ADDR_W-1:0]  address;
	logic [ADDR_W-1:0]  copy_address;
	logic [DATA_W-1:0]  data_word;

	modport source (output valid, req_type, entry_index, word_index, address, copy_address,
		data_word, input ready);
	modport sink (input valid, req_type, entry_index, word_index, address, copy_address,
		data_word, output ready);
endinterface

interface lscbf_rsp_if import lscbf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] fetched_address;
	logic [WIDX_W-1:0] out_word_index;
	logic [DATA_W-1:0] block_word;
	logic              hit;
	logic              last;

	modport source (output valid, fetched_address, out_word_index, block_word, hit, last,
		input ready);
	modport sink (input valid, fetched_address, out_word_index, block_word, hit, last,
		output ready);
endinterface

/* rtl/lscbf_ram.sv */
// ----------------------------------------------------------------------------
// lscbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lscbf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/lscbf_engine.sv */
// ----------------------------------------------------------------------------
// lscbf_engine
// Table storage, scan sequencer and the shared 64-bit address comparator.
// ----------------------------------------------------------------------------
`include "linear_scan_code_block_fetch_top_macros.svh"

module lscbf_engine import lscbf_pkg::*; #(
	parameter int MAX_REMAP       = 256,
	parameter int MAX_BLOCKS      = 1024,
	parameter int WORDS_PER_BLOCK = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lscbf_counts_t counts,
	lscbf_req_if.sink     req,
	lscbf_rsp_if.source   rsp
);

	localparam int RA_W   = (MAX_REMAP > 1) ? $clog2(MAX_REMAP) : 1;
	localparam int BA_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int WA_W   = $clog2(MAX_BLOCKS * WORDS_PER_BLOCK);
	localparam int WW     = $clog2(WORDS_PER_BLOCK);
	localparam int SC_MAX = (MAX_REMAP > MAX_BLOCKS) ? MAX_REMAP : MAX_BLOCKS;
	localparam int SC_W   = $clog2(SC_MAX + 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_REMAP = 5'b00010,
		ST_BLOCK = 5'b00100,
		ST_FRD   = 5'b01000,
		ST_FWR   = 5'b10000
	} state_t;

	state_t            state_q;
	logic [SC_W-1:0]   scan_q;
	logic              pend_s1;
	logic [SC_W-1:0]   pend_idx_s1;
	logic [ADDR_W-1:0] query_q;
	logic [ADDR_W-1:0] target_q;
	logic              found_q;
	logic [WA_W-1:0]   base_q;
	logic [WW-1:0]     w_q;

	logic              out_valid_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [WIDX_W-1:0] out_widx_q;
	logic [DATA_W-1:0] out_word_q;
	logic              out_hit_q;
	logic              out_last_q;

	logic              acc;
	logic [31:0]       entry_ext;
	logic [31:0]       word_ext;
	logic [31:0]       w_ext;
	logic              remap_we;
	logic              blk_we;
	logic [SC_W-1:0]   nr;
	logic [SC_W-1:0]   nb;
	logic [SC_W-1:0]   scan_lim;
	logic              issue;
	logic              cmp_eq;
	logic [ADDR_W-1:0] cmp_a;
	logic [ADDR_W-1:0] cmp_b;
	logic              w_last;
	logic              out_load;
	logic [WA_W-1:0]   match_base;

	logic [ADDR_W-1:0] orig_rdata;
	logic [ADDR_W-1:0] copy_rdata;
	logic [ADDR_W-1:0] baddr_rdata;
	logic [DATA_W-1:0] word_rdata;

	// Accept only while the sequencer is idle
	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign entry_ext = 32'(req.entry_index);
	assign word_ext  = 32'(req.word_index);

	// Drop loads that fall outside the tables
	assign remap_we = acc && (req.req_type == REQ_REMAP) && (entry_ext < MAX_REMAP);
	assign blk_we   = acc && (req.req_type == REQ_BLOCK) && (entry_ext < MAX_BLOCKS) &&
		(word_ext < WORDS_PER_BLOCK);

	// Saturate the fill counts to the table depths
	always_comb begin
		if (32'(counts.remap_count) > MAX_REMAP) begin
			nr = SC_W'(MAX_REMAP);
		end else begin
			nr = SC_W'(counts.remap_count);
		end
		if (32'(counts.block_count) > MAX_BLOCKS) begin
			nb = SC_W'(MAX_BLOCKS);
		end else begin
			nb = SC_W'(counts.block_count);
		end
	end

	assign scan_lim = (state_q == ST_REMAP) ? nr : nb;
	assign issue    = (scan_q < scan_lim);

	// Shared address comparator: remap originals against the query, then
	// block addresses against the translated address
	assign cmp_a  = (state_q == ST_REMAP) ? query_q : target_q;
	assign cmp_b  = (state_q == ST_REMAP) ? orig_rdata : baddr_rdata;
	assign cmp_eq = (cmp_a == cmp_b);

	assign match_base = WA_W'(32'(pend_idx_s1[BA_W-1:0]) * WORDS_PER_BLOCK);
	assign w_ext      = 32'(w_q);
	assign w_last     = (w_q == WW'(WORDS_PER_BLOCK - 1));
	assign out_load   = (state_q == ST_FWR) && (!out_valid_q || rsp.ready);

	// Table storage
	lscbf_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_REMAP)) u_remap_orig (
		.clk   (clk),
		.we    (remap_we),
		.waddr (entry_ext[RA_W-1:0]),
		.wdata (req.address),
		.raddr (scan_q[RA_W-1:0]),
		.rdata (orig_rdata)
	);

	lscbf_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_REMAP)) u_remap_copy (
		.clk   (clk),
		.we    (remap_we),
		.waddr (entry_ext[RA_W-1:0]),
		.wdata (req.copy_address),
		.raddr (scan_q[RA_W-1:0]),
		.rdata (copy_rdata)
	);

	lscbf_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_BLOCKS)) u_block_addr (
		.clk   (clk),
		.we    (blk_we),
		.waddr (entry_ext[BA_W-1:0]),
		.wdata (req.address),
		.raddr (scan_q[BA_W-1:0]),
		.rdata (baddr_rdata)
	);

	lscbf_ram #(.WIDTH(DATA_W), .DEPTH(MAX_BLOCKS * WORDS_PER_BLOCK)) u_block_words (
		.clk   (clk),
		.we    (blk_we),
		.waddr (WA_W'(entry_ext * WORDS_PER_BLOCK + word_ext)),
		.wdata (req.data_word),
		.raddr (base_q + WA_W'(w_q)),
		.rdata (word_rdata)
	);

	// Sequencer: remap scan, block scan, then word fetch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			pend_s1     <= 1'b0;
			pend_idx_s1 <= '0;
			query_q     <= '0;
			target_q    <= '0;
			found_q     <= 1'b0;
			base_q      <= '0;
			w_q         <= '0;
			out_valid_q <= 1'b0;
			out_addr_q  <= '0;
			out_widx_q  <= '0;
			out_word_q  <= '0;
			out_hit_q   <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			// Drop the held word once it is transferred
			if (rsp.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc && (req.req_type == REQ_QUERY)) begin
						query_q  <= req.address;
						target_q <= req.address;
						found_q  <= 1'b0;
						base_q   <= '0;
						scan_q   <= '0;
						pend_s1  <= 1'b0;
						state_q  <= ST_REMAP;
					end
				end
				ST_REMAP, ST_BLOCK: begin
					pend_s1     <= issue;
					pend_idx_s1 <= scan_q;
					if (issue) begin
						scan_q <= scan_q + 1'b1;
					end
					// Last match wins in both scans
					if (pend_s1 && cmp_eq) begin
						if (state_q == ST_REMAP) begin
							target_q <= copy_rdata;
						end else begin
							found_q <= 1'b1;
							base_q  <= match_base;
						end
					end
					if (!issue && !pend_s1) begin
						scan_q <= '0;
						if (state_q == ST_REMAP) begin
							state_q <= ST_BLOCK;
						end else begin
							w_q     <= '0;
							state_q <= ST_FRD;
						end
					end
				end
				ST_FRD: begin
					state_q <= ST_FWR;
				end
				ST_FWR: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						out_addr_q  <= target_q;
						out_widx_q  <= w_ext[WIDX_W-1:0];
						out_word_q  <= found_q ? word_rdata : '0;
						out_hit_q   <= found_q;
						out_last_q  <= w_last;
						if (w_last) begin
							state_q <= ST_IDLE;
						end else begin
							w_q     <= w_q + 1'b1;
							state_q <= ST_FRD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.fetched_address = out_addr_q;
	assign rsp.out_word_index  = out_widx_q;
	assign rsp.block_word      = out_word_q;
	assign rsp.hit             = out_hit_q;
	assign rsp.last            = out_last_q;

	// Checks
	`LSCBF_ASSERT(a_miss_zero, !(out_valid_q && !out_hit_q) || (out_word_q == '0), "miss word not zero")
	`LSCBF_ASSERT(a_pend_scan, !pend_s1 || (state_q == ST_REMAP) || (state_q == ST_BLOCK), "compare outside scan")
	`LSCBF_ASSERT(a_scan_bound, !((state_q == ST_REMAP) || (state_q == ST_BLOCK)) || (scan_q <= scan_lim), "scan overrun")
	`LSCBF_ASSERT_NEXT(a_last_idle, out_load && w_last, (state_q == ST_IDLE) && out_valid_q && out_last_q, "no return to idle")

endmodule

/* rtl/linear_scan_code_block_fetch_top.sv */
// Flow: the block takes one item at a time and accepts nothing until a query's last word is
// loaded. One shared comparator scans both tables one entry per cycle, up to the saturated
// remap/block counts; then each of the WORDS_PER_BLOCK words is read in ST_FRD and loaded
// into the output register in ST_FWR, which waits while the output is stalled.
// Reset: arst_n clears the sequencer, the output register and both counts; tables are
// undefined until loaded.
// ----------------------------------------------------------------------------
// linear_scan_code_block_fetch_top
// Oblivious code-block fetch: remap lookup, full block scan, word readout.
// ----------------------------------------------------------------------------
module linear_scan_code_block_fetch_top import lscbf_pkg::*; #(
	parameter int MAX_REMAP       = 256,
	parameter int MAX_BLOCKS      = 1024,
	parameter int WORDS_PER_BLOCK = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lscbf_req_if.sink             req,
	lscbf_rsp_if.source           rsp
);

	lscbf_counts_t counts_q;

	// Hold the fill counts; ignore writes beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counts_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BLOCK_COUNT: counts_q.block_count <= cfg_data[BCOUNT_W-1:0];
				CFG_REMAP_COUNT: counts_q.remap_count <= cfg_data[RCOUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lscbf_engine #(
		.MAX_REMAP       (MAX_REMAP),
		.MAX_BLOCKS      (MAX_BLOCKS),
		.WORDS_PER_BLOCK (WORDS_PER_BLOCK)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.counts (counts_q),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

/* tb/tb_linear_scan_code_block_fetch_top.sv */
// ----------------------------------------------------------------------------
// tb_linear_scan_code_block_fetch_top
// Self-checking bench for the linear-scan code-block fetch. Remap pairs and
// block words are loaded over the request channel. Queries then scan both
// tables, and every fetched-word transfer is compared field by field with a
// prediction of the remap lookup and the last-match block scan. Table entries
// are always written before any query can reach them.
// ----------------------------------------------------------------------------
module tb_linear_scan_code_block_fetch_top;
	import lscbf_pkg::*;

	localparam int REMAP_DEPTH     = 256;
	localparam int BLOCK_DEPTH     = 1024;
	localparam int BLOCK_WORDS     = 16;
	localparam int POOL_SIZE       = 6;
	localparam int IDLE_PCT        = 17;
	localparam int CYCLE_LIMIT     = 400000;

	localparam logic [1:0]        REQ_UNKNOWN = 2'd3;
	localparam logic [DATA_W-1:0] ALL_ONES    = {DATA_W{1'b1}};
	localparam logic [DATA_W-1:0] ALL_ZEROS   = {DATA_W{1'b0}};

	typedef struct {
		logic [ADDR_W-1:0] fetched_address;
		logic [WIDX_W-1:0] out_word_index;
		logic [DATA_W-1:0] block_word;
		logic              hit;
		logic              last;
	} fetch_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	lscbf_req_if req_ch ();
	lscbf_rsp_if rsp_ch ();

	linear_scan_code_block_fetch_top #(
		.MAX_REMAP       (REMAP_DEPTH),
		.MAX_BLOCKS      (BLOCK_DEPTH),
		.WORDS_PER_BLOCK (BLOCK_WORDS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Mirror of the tables and counts, plus which entries have been written
	logic [ADDR_W-1:0]    remap_orig [REMAP_DEPTH];
	logic [ADDR_W-1:0]    remap_copy [REMAP_DEPTH];
	bit                   remap_written [REMAP_DEPTH];
	logic [ADDR_W-1:0]    block_addr [BLOCK_DEPTH];
	logic [DATA_W-1:0]    block_data [BLOCK_DEPTH][BLOCK_WORDS];
	bit [BLOCK_WORDS-1:0] block_filled [BLOCK_DEPTH];
	bit                   block_addr_written [BLOCK_DEPTH];
	int unsigned          block_count_q;
	int unsigned          remap_count_q;

	fetch_word_t       fetch_expected [$];
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
	int unsigned       mismatch_count;
	int unsigned       items_done;
	int unsigned       cycle_count;
	bit                calm;

	// Clock: period of 2
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int unsigned remap_span();
		return (remap_count_q > REMAP_DEPTH) ? REMAP_DEPTH : remap_count_q;
	endfunction

	function automatic int unsigned block_span();
		return (block_count_q > BLOCK_DEPTH) ? BLOCK_DEPTH : block_count_q;
	endfunction

	function automatic int unsigned remap_prefix();
		for (int unsigned i = 0; i < REMAP_DEPTH; i++)
			if (!remap_written[i]) return i;
		return REMAP_DEPTH;
	endfunction

	function automatic int unsigned block_prefix();
		for (int unsigned i = 0; i < BLOCK_DEPTH; i++)
			if (!block_addr_written[i]) return i;
		return BLOCK_DEPTH;
	endfunction

	// Translate through the last matching remap pair, then find the last matching block
	function automatic void scan_tables(input logic [ADDR_W-1:0] query,
			output logic [ADDR_W-1:0] target, output bit found, output int unsigned sel);
		target = query;
		found  = 1'b0;
		sel    = 0;
		for (int unsigned i = 0; i < remap_span(); i++)
			if (remap_orig[i] === query) target = remap_copy[i];
		for (int unsigned i = 0; i < block_span(); i++)
			if (block_addr[i] === target) begin
				found = 1'b1;
				sel   = i;
			end
	endfunction

	// A query may only touch written entries and a fully written matching block
	function automatic bit query_is_safe(input logic [ADDR_W-1:0] query);
		logic [ADDR_W-1:0] target;
		bit                found;
		int unsigned       sel;
		for (int unsigned i = 0; i < remap_span(); i++)
			if (!remap_written[i]) return 1'b0;
		for (int unsigned i = 0; i < block_span(); i++)
			if (!block_addr_written[i]) return 1'b0;
		scan_tables(query, target, found, sel);
		return !found || (block_filled[sel] == '1);
	endfunction

	// Update the tables or queue the fetched words; report whether the item acts
	function automatic bit apply_request(input logic [1:0] kind,
			input logic [ENTRY_W-1:0] entry, input logic [WIDX_W-1:0] widx,
			input logic [ADDR_W-1:0] addr, input logic [ADDR_W-1:0] copy,
			input logic [DATA_W-1:0] data);
		logic [ADDR_W-1:0] target;
		bit                found;
		int unsigned       sel;
		case (kind)
			REQ_REMAP: begin
				if (entry >= REMAP_DEPTH) return 1'b0;
				remap_orig[entry]    = addr;
				remap_copy[entry]    = copy;
				remap_written[entry] = 1'b1;
				return 1'b1;
			end
			REQ_BLOCK: begin
				block_addr[entry]         = addr;
				block_data[entry][widx]   = data;
				block_filled[entry][widx] = 1'b1;
				block_addr_written[entry] = 1'b1;
				return 1'b1;
			end
			REQ_QUERY: begin
				scan_tables(addr, target, found, sel);
				for (int w = 0; w < BLOCK_WORDS; w++)
					fetch_expected.push_back('{target, WIDX_W'(w),
						found ? block_data[sel][w] : ALL_ZEROS, found, w == BLOCK_WORDS - 1});
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("cycle %0d: fetched word %s: got %h, want %h", cycle_count, field, got, want);
		mismatch_count++;
	endtask

	// Drive one request; leave valid high so the next one can follow directly
	task automatic send_request(input logic [1:0] kind, input logic [ENTRY_W-1:0] entry,
			input logic [WIDX_W-1:0] widx, input logic [ADDR_W-1:0] addr,
			input logic [ADDR_W-1:0] copy, input logic [DATA_W-1:0] data);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < 50);
		end
		req_ch.valid        <= 1'b1;
		req_ch.req_type     <= kind;
		req_ch.entry_index  <= entry;
		req_ch.word_index   <= widx;
		req_ch.address      <= addr;
		req_ch.copy_address <= copy;
		req_ch.data_word    <= data;
		do @(posedge clk); while (!req_ch.ready);
		if (apply_request(kind, entry, widx, addr, copy, data)) items_done++;
		@(negedge clk);
	endtask

	task automatic load_remap(input int unsigned entry, input logic [ADDR_W-1:0] orig,
			input logic [ADDR_W-1:0] copy);
		send_request(REQ_REMAP, ENTRY_W'(entry), WIDX_W'($urandom), orig, copy, rand64());
	endtask

	// Write all words of one block, in a random odd-stride order
	task automatic load_full_block(input int unsigned entry, input logic [ADDR_W-1:0] addr);
		int unsigned first;
		int unsigned stride;
		first  = $urandom_range(BLOCK_WORDS - 1);
		stride = 2 * $urandom_range(BLOCK_WORDS / 2 - 1) + 1;
		for (int k = 0; k < BLOCK_WORDS; k++)
			send_request(REQ_BLOCK, ENTRY_W'(entry), WIDX_W'((first + k * stride) % BLOCK_WORDS),
				addr, rand64(), rand64());
	endtask

	// Fall back to a fresh address where the candidate would read unwritten words
	task automatic send_query(input logic [ADDR_W-1:0] addr);
		if (!query_is_safe(addr)) addr = rand64();
		if (query_is_safe(addr))
			send_request(REQ_QUERY, ENTRY_W'($urandom), WIDX_W'($urandom), addr, rand64(),
				rand64());
	endtask

	// Hold requests until every fetched word has arrived and the block has settled
	task automatic settle_block();
		req_ch.valid <= 1'b0;
		while (fetch_expected.size() != 0) @(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_counts(input int unsigned blocks, input int unsigned remaps);
		settle_block();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_BLOCK_COUNT;
		cfg_data  <= CFG_DATA_W'(blocks);
		@(negedge clk);
		cfg_index <= CFG_REMAP_COUNT;
		cfg_data  <= CFG_DATA_W'(remaps);
		@(negedge clk);
		cfg_we        <= 1'b0;
		block_count_q = blocks % (1 << BCOUNT_W);
		remap_count_q = remaps % (1 << RCOUNT_W);
	endtask

	task automatic test_directed_cases();
		logic [ADDR_W-1:0] far_addr;
		far_addr = 64'h8000_0000_0000_0000;
		// Two blocks under the all-ones address: the later entry must win
		send_request(REQ_BLOCK, ENTRY_W'(0), WIDX_W'(3), ALL_ONES, rand64(), rand64());
		for (int w = BLOCK_WORDS - 1; w >= 0; w--)
			send_request(REQ_BLOCK, ENTRY_W'(1), WIDX_W'(w), ALL_ONES, rand64(),
				(w == 0) ? ALL_ZEROS : (w == BLOCK_WORDS - 1) ? ALL_ONES : rand64());
		// Zero original address twice: the later pair must win
		load_remap(0, ALL_ZEROS, far_addr);
		load_remap(1, ALL_ZEROS, ALL_ONES);
		// Dropped items: unknown type, remap entry past the table end
		send_request(REQ_UNKNOWN, '1, '1, rand64(), rand64(), rand64());
		send_request(REQ_REMAP, ENTRY_W'(REMAP_DEPTH), WIDX_W'(0), ALL_ZEROS, rand64(),
			rand64());
		write_counts(2, 2);
		send_query(ALL_ZEROS);
		send_query(ALL_ONES);
		// Remap to an address with no block behind it
		write_counts(2, 1);
		send_query(ALL_ZEROS);
		send_query(ALL_ONES);
		// Empty tables: address passes through, nothing hits
		write_counts(0, 0);
		send_query(ALL_ZEROS);
	endtask

	task automatic test_random_traffic();
		int unsigned       start;
		int unsigned       blocks;
		int unsigned       remaps;
		int unsigned       pick;
		int unsigned       entry;
		int unsigned       grow_b;
		int unsigned       grow_r;
		bit                paused;
		logic [ADDR_W-1:0] addr;
		paused       = 1'b0;
		addr_pool[0] = ALL_ZEROS;
		addr_pool[1] = ALL_ONES;
		for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = rand64();
		for (int phase = 0; phase < 6; phase++) begin
			grow_b = block_prefix();
			grow_r = remap_prefix();
			blocks = $urandom_range((grow_b < 40) ? grow_b : 40);
			remaps = $urandom_range((grow_r < 20) ? grow_r : 20);
			calm   = (phase == 3);
			write_counts(blocks, remaps);
			start = items_done;
			while (items_done - start < 62) begin
				// Stop mid-phase once and let every outstanding word drain
				if (phase == 2 && !paused && items_done - start >= 31) begin
					settle_block();
					paused = 1'b1;
				end
				pick   = $urandom_range(99);
				grow_b = block_prefix();
				grow_r = remap_prefix();
				if (pick < 35) begin
					case ($urandom_range(9))
						0, 1, 2, 3, 4: addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
						5, 6: addr = (remaps != 0) ? remap_orig[$urandom_range(remaps - 1)] : rand64();
						default: addr = rand64();
					endcase
					send_query(addr);
				end else if (pick < 47) begin
					entry = ($urandom_range(1) && grow_b < BLOCK_DEPTH) ? grow_b
						: $urandom_range(blocks + 3);
					load_full_block(entry, addr_pool[$urandom_range(POOL_SIZE - 1)]);
				end else if (pick < 70) begin
					entry = ($urandom_range(3) == 0 && grow_b < BLOCK_DEPTH) ? grow_b
						: $urandom_range(blocks + 3);
					addr  = block_addr_written[entry] ? block_addr[entry]
						: addr_pool[$urandom_range(POOL_SIZE - 1)];
					send_request(REQ_BLOCK, ENTRY_W'(entry), WIDX_W'($urandom), addr, rand64(),
						rand64());
				end else if (pick < 90) begin
					entry = ($urandom_range(1) && grow_r < REMAP_DEPTH) ? grow_r
						: $urandom_range(remaps + 3);
					load_remap(entry, $urandom_range(3) ? addr_pool[$urandom_range(POOL_SIZE - 1)]
						: rand64(), addr_pool[$urandom_range(POOL_SIZE - 1)]);
				end else if ($urandom_range(1)) begin
					send_request(REQ_UNKNOWN, ENTRY_W'($urandom), WIDX_W'($urandom), rand64(),
						rand64(), rand64());
				end else begin
					send_request(REQ_REMAP, ENTRY_W'($urandom_range(BLOCK_DEPTH - 1, REMAP_DEPTH)),
						WIDX_W'($urandom), rand64(), rand64(), rand64());
				end
			end
		end
		calm = 1'b0;
	endtask

	// Scan the whole written run of both tables, with the match at its far end
	task automatic test_long_scan();
		logic [ADDR_W-1:0] key;
		logic [ADDR_W-1:0] alias_addr;
		int unsigned       top_b;
		int unsigned       top_r;
		key        = rand64();
		alias_addr = rand64();
		top_b      = block_prefix();
		top_r      = remap_prefix();
		if (top_b > BLOCK_DEPTH - 1) top_b = BLOCK_DEPTH - 1;
		if (top_r > REMAP_DEPTH - 2) top_r = REMAP_DEPTH - 2;
		// An earlier entry with the key must lose to the last entry
		send_request(REQ_BLOCK, ENTRY_W'(top_b / 2), WIDX_W'($urandom), key, rand64(),
			rand64());
		load_full_block(top_b, key);
		load_remap(top_r, alias_addr, key);
		write_counts(top_b + 1, top_r + 1);
		send_query(alias_addr);
		send_query(key);
		send_query(rand64());
		// Empty remap table: the alias passes through unchanged
		write_counts(top_b + 1, 0);
		send_query(alias_addr);
	endtask

	// Stall the fetched-word channel at random, except in calm stretches
	always @(negedge clk) rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

	// Compare each fetched-word transfer with the oldest expectation
	always @(posedge clk) begin : word_check
		fetch_word_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (fetch_expected.size() == 0) begin
				report_mismatch("with none expected", rsp_ch.block_word, ALL_ZEROS);
			end else begin
				want = fetch_expected.pop_front();
				if (rsp_ch.fetched_address !== want.fetched_address)
					report_mismatch("fetched_address", rsp_ch.fetched_address, want.fetched_address);
				if (rsp_ch.out_word_index !== want.out_word_index)
					report_mismatch("out_word_index", rsp_ch.out_word_index, want.out_word_index);
				if (rsp_ch.block_word !== want.block_word)
					report_mismatch("block_word", rsp_ch.block_word, want.block_word);
				if (rsp_ch.hit !== want.hit)
					report_mismatch("hit", rsp_ch.hit, want.hit);
				if (rsp_ch.last !== want.last)
					report_mismatch("last", rsp_ch.last, want.last);
			end
		end
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = CFG_BLOCK_COUNT;
		cfg_data            = '0;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = REQ_REMAP;
		req_ch.entry_index  = '0;
		req_ch.word_index   = '0;
		req_ch.address      = '0;
		req_ch.copy_address = '0;
		req_ch.data_word    = '0;
		rsp_ch.ready        = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_cases();
		test_random_traffic();
		test_long_scan();

		// Drain, then leave room for any stray words
		settle_block();
		repeat (1400) @(negedge clk);
		if (mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

/* linear_scan_code_block_fetch_top.f */
+incdir+rtl
rtl/lscbf_pkg.sv
rtl/lscbf_if.sv
rtl/lscbf_ram.sv
rtl/lscbf_engine.sv
rtl/linear_scan_code_block_fetch_top.sv
tb/tb_linear_scan_code_block_fetch_top.sv
